@@ rtl/core/mldp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mldp_pkg
// Shared types and constants for the LZ depacker.
// ----------------------------------------------------------------------------
package mldp_pkg;

  localparam logic [15:0] DISP_SHORT_BASE = 16'hFFF8;
  localparam logic [15:0] DISP_BYTE_BASE  = 16'hFF00;
  localparam logic [7:0]  DISP_HI_BASE    = 8'hF0;
  localparam logic [3:0]  BYTE_BITS       = 4'd8;
  localparam logic [3:0]  END_PREFIX      = 4'd8;

  typedef enum logic [12:0] {
    PH_IDLE     = 13'b0000000000001,
    PH_SEED     = 13'b0000000000010,
    PH_TOP      = 13'b0000000000100,
    PH_LIT      = 13'b0000000001000,
    PH_SEL      = 13'b0000000010000,
    PH_SHORT    = 13'b0000000100000,
    PH_BYTE2    = 13'b0000001000000,
    PH_PREFIX   = 13'b0000010000000,
    PH_LENBITS  = 13'b0000100000000,
    PH_BIGFLAG  = 13'b0001000000000,
    PH_BIGHI    = 13'b0010000000000,
    PH_BIGLOW   = 13'b0100000000000,
    PH_BIGSHORT = 13'b1000000000000
  } phase_e;

  typedef enum logic [4:0] {
    CT_IDLE  = 5'b00001,
    CT_PARSE = 5'b00010,
    CT_RD    = 5'b00100,
    CT_WR    = 5'b01000,
    CT_FLUSH = 5'b10000
  } ctl_e;

  typedef enum logic [1:0] {
    SEL_SHORT = 2'd0,
    SEL_BYTE  = 2'd1,
    SEL_THREE = 2'd2,
    SEL_LONG  = 2'd3
  } sel_e;

endpackage

@@ rtl/core/mldp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mldp_in_if / mldp_out_if
// Valid/ready channels for packed input bytes and unpacked result words.
// ----------------------------------------------------------------------------
interface mldp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       stream_start;
  modport source (output valid, packed_byte, stream_start, input ready);
  modport sink   (input valid, packed_byte, stream_start, output ready);
endinterface

interface mldp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_bytes;
  logic [3:0]  byte_count;
  logic        run_last;
  logic        end_of_stream;
  modport source (output valid, out_bytes, byte_count, run_last, end_of_stream, input ready);
  modport sink   (input valid, out_bytes, byte_count, run_last, end_of_stream, output ready);
endinterface

@@ rtl/core/megalz_depacker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// megalz_depacker
// Streaming LZ depacker: bit-code parser, history window copy, byte packer.
// ----------------------------------------------------------------------------
// Steps: take a byte, then the parse steps (a code bit, a data
//   byte, or the decision after a gathered field), a window read then write
//   back per copied byte, and a flush of the packed word.
// A new input byte is taken only once the last one is parsed and its copies
//   are done; result stalls hold the packer and the copy loop.
// Reset: async, active low; clears parser and packer, no stream open. The
//   window is not cleared; it is only read where already written.
module megalz_depacker #(
  parameter int WINDOW_SIZE = 8192,
  parameter int OUT_LANES   = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mldp_in_if.sink       in_i,
  mldp_out_if.source    out_o
);
  import mldp_pkg::*;

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam int LW = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;
  localparam logic [3:0] LANES = 4'(OUT_LANES);

  // history window, one write and one registered read per cycle
  logic [7:0]    win_mem [WINDOW_SIZE];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd, mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) win_mem[mem_wa] <= mem_wd;
    if (mem_re) mem_rd_q <= win_mem[mem_ra];
  end

  ctl_e   ctl_q, ctl_d;
  phase_e ph_q, ph_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [7:0] bb_q, bb_d, cur_q, cur_d, lb_q, lb_d, plen_q, plen_d, dh_q, dh_d;
  logic [7:0] cnt_q, cnt_d;
  logic [15:0] disp_q, disp_d;
  logic [3:0] bl_q, bl_d, pc_q, pc_d, gc_q, gc_d;
  logic have_q, have_d, done_q, done_d, ended_q, ended_d;
  logic [OUT_LANES-1:0][7:0] pk_q, pk_d;
  logic [3:0] pkc_q, pkc_d;

  // output register
  logic        ov_q, ov_d, ol_q, ol_d, oe_q, oe_d;
  logic [63:0] ob_q, ob_d;
  logic [3:0]  oc_q, oc_d;

  logic       can_push, push_en, take_bit, bit_ok, bit_v, out_free;
  logic [7:0] push_b;
  logic [3:0] pc_inc;

  assign in_i.ready          = (ctl_q == CT_IDLE);
  assign out_o.valid         = ov_q;
  assign out_o.out_bytes     = ob_q;
  assign out_o.byte_count    = oc_q;
  assign out_o.run_last      = ol_q;
  assign out_o.end_of_stream = oe_q;

  assign out_free = !ov_q || out_o.ready;
  assign can_push = (pkc_q != LANES) || out_free;
  assign bit_ok   = (bl_q != 4'd0) || have_q;
  assign bit_v    = (bl_q != 4'd0) ? bb_q[7] : cur_q[7];
  assign pc_inc   = (pc_q < END_PREFIX) ? pc_q + 4'd1 : pc_q;

  always_comb begin
    ctl_d = ctl_q;  ph_d = ph_q;  wp_d = wp_q;  bb_d = bb_q;  cur_d = cur_q;
    lb_d = lb_q;  plen_d = plen_q;  dh_d = dh_q;  cnt_d = cnt_q;  disp_d = disp_q;
    bl_d = bl_q;  pc_d = pc_q;  gc_d = gc_q;  have_d = have_q;  done_d = done_q;
    ended_d = ended_q;  pk_d = pk_q;  pkc_d = pkc_q;
    ov_d = ov_q;  ol_d = ol_q;  oe_d = oe_q;  ob_d = ob_q;  oc_d = oc_q;
    push_en = 1'b0;  push_b = 8'd0;  take_bit = 1'b0;
    mem_re = 1'b0;  mem_ra = AW'(wp_q + disp_q[AW-1:0]);

    if (ov_q && out_o.ready) ov_d = 1'b0;

    case (ctl_q)
      CT_IDLE: begin
        if (in_i.valid) begin
          if (in_i.stream_start) begin
            wp_d = '0;  bb_d = '0;  bl_d = '0;  pc_d = '0;  lb_d = '0;  gc_d = '0;
            plen_d = '0;  dh_d = '0;  done_d = 1'b0;
            push_en = 1'b1;  push_b = in_i.packed_byte;
            ph_d = PH_SEED;  ctl_d = CT_FLUSH;
          end else if (!done_q) begin
            have_d = 1'b1;  cur_d = in_i.packed_byte;  ctl_d = CT_PARSE;
          end
        end
      end
      CT_PARSE: begin
        case (ph_q)
          PH_SEED: begin
            if (!have_q) ctl_d = CT_FLUSH;
            else begin
              bb_d = cur_q;  bl_d = BYTE_BITS;  have_d = 1'b0;  ph_d = PH_TOP;
            end
          end
          PH_TOP: begin
            if (!bit_ok) ctl_d = CT_FLUSH;
            else begin
              take_bit = 1'b1;
              if (bit_v) ph_d = PH_LIT;
              else begin gc_d = '0; lb_d = '0; ph_d = PH_SEL; end
            end
          end
          PH_LIT: begin
            if (!have_q) ctl_d = CT_FLUSH;
            else if (can_push) begin
              push_en = 1'b1;  push_b = cur_q;  have_d = 1'b0;  ph_d = PH_TOP;
            end
          end
          PH_SEL, PH_SHORT, PH_LENBITS, PH_BIGHI: begin
            logic [3:0] need;
            need = (ph_q == PH_SEL) ? 4'd2 : (ph_q == PH_SHORT) ? 4'd3 :
                   (ph_q == PH_BIGHI) ? 4'd4 : pc_q;
            if (gc_q < need) begin
              if (!bit_ok) ctl_d = CT_FLUSH;
              else begin
                take_bit = 1'b1;  lb_d = {lb_q[6:0], bit_v};  gc_d = gc_q + 4'd1;
              end
            end else begin
              case (ph_q)
                PH_SEL: begin
                  case (sel_e'(lb_q[1:0]))
                    SEL_SHORT: begin gc_d = '0; lb_d = '0; ph_d = PH_SHORT; end
                    SEL_BYTE:  ph_d = PH_BYTE2;
                    SEL_THREE: begin plen_d = 8'd3; ph_d = PH_BIGFLAG; end
                    default:   begin pc_d = '0; ph_d = PH_PREFIX; end
                  endcase
                end
                PH_SHORT: begin
                  disp_d = DISP_SHORT_BASE | {8'd0, lb_q};  cnt_d = 8'd1;
                  ph_d = PH_TOP;  ctl_d = CT_RD;
                end
                PH_LENBITS: begin
                  plen_d = 8'd2 + (8'd1 << pc_q) + lb_q;  ph_d = PH_BIGFLAG;
                end
                default: begin
                  dh_d = (DISP_HI_BASE | lb_q) - 8'd1;  ph_d = PH_BIGLOW;
                end
              endcase
            end
          end
          PH_BYTE2, PH_BIGLOW, PH_BIGSHORT: begin
            if (!have_q) ctl_d = CT_FLUSH;
            else begin
              have_d = 1'b0;  ph_d = PH_TOP;
              disp_d = (ph_q == PH_BIGLOW) ? {dh_q, cur_q} : (DISP_BYTE_BASE | {8'd0, cur_q});
              cnt_d  = (ph_q == PH_BYTE2) ? 8'd2 : plen_q;
              if (!(ph_q != PH_BYTE2 && plen_q == 8'd0)) ctl_d = CT_RD;
            end
          end
          PH_PREFIX: begin
            if (!bit_ok) ctl_d = CT_FLUSH;
            else begin
              take_bit = 1'b1;  pc_d = pc_inc;
              if (bit_v) begin
                if (pc_inc >= END_PREFIX) begin
                  ph_d = PH_IDLE;  done_d = 1'b1;  ended_d = 1'b1;  ctl_d = CT_FLUSH;
                end else begin
                  gc_d = '0;  lb_d = '0;  ph_d = PH_LENBITS;
                end
              end
            end
          end
          PH_BIGFLAG: begin
            if (!bit_ok) ctl_d = CT_FLUSH;
            else begin
              take_bit = 1'b1;
              if (bit_v) begin gc_d = '0; lb_d = '0; ph_d = PH_BIGHI; end
              else ph_d = PH_BIGSHORT;
            end
          end
          default: ctl_d = CT_FLUSH;
        endcase
      end
      CT_RD: begin
        mem_re = 1'b1;  ctl_d = CT_WR;
      end
      CT_WR: begin
        if (can_push) begin
          push_en = 1'b1;  push_b = mem_rd_q;  cnt_d = cnt_q - 8'd1;
          ctl_d = (cnt_q == 8'd1) ? CT_PARSE : CT_RD;
        end
      end
      CT_FLUSH: begin
        if (pkc_q != 4'd0 || ended_q) begin
          if (out_free) begin
            ov_d = 1'b1;  ob_d = 64'(pk_q);  oc_d = pkc_q;  ol_d = 1'b1;  oe_d = ended_q;
            pk_d = '0;  pkc_d = '0;  ended_d = 1'b0;  ctl_d = CT_IDLE;
          end
        end else ctl_d = CT_IDLE;
      end
      default: ctl_d = CT_IDLE;
    endcase

    // the end code drops what is left of the bit buffer
    if (ended_d && !ended_q) begin
      bb_d = '0;  bl_d = '0;  have_d = 1'b0;
    end else if (take_bit) begin
      if (bl_q == 4'd0) begin
        bb_d = {cur_q[6:0], 1'b0};  bl_d = BYTE_BITS - 4'd1;  have_d = 1'b0;
      end else begin
        bb_d = {bb_q[6:0], 1'b0};  bl_d = bl_q - 4'd1;
      end
    end

    // a full packer waits: the next byte sends it as not the last, a flush as the last
    if (push_en) begin
      wp_d = mem_wa + AW'(1);
      if (pkc_q == LANES) begin
        ov_d = 1'b1;  ob_d = 64'(pk_q);  oc_d = pkc_q;  ol_d = 1'b0;  oe_d = 1'b0;
        pk_d = '0;  pk_d[0] = push_b;  pkc_d = 4'd1;
      end else begin
        pk_d[pkc_q[LW-1:0]] = push_b;  pkc_d = pkc_q + 4'd1;
      end
    end
  end

  // the only push from idle is the first byte of a new stream, at entry 0
  assign mem_we = push_en;
  assign mem_wa = (ctl_q == CT_IDLE) ? '0 : wp_q;
  assign mem_wd = push_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= CT_IDLE;  ph_q <= PH_IDLE;  wp_q <= '0;  bb_q <= '0;  bl_q <= '0;
      pc_q <= '0;  lb_q <= '0;  gc_q <= '0;  plen_q <= '0;  dh_q <= '0;
      have_q <= 1'b0;  done_q <= 1'b1;  ended_q <= 1'b0;  pk_q <= '0;  pkc_q <= '0;
      ov_q <= 1'b0;
    end else begin
      ctl_q <= ctl_d;  ph_q <= ph_d;  wp_q <= wp_d;  bb_q <= bb_d;  bl_q <= bl_d;
      pc_q <= pc_d;  lb_q <= lb_d;  gc_q <= gc_d;  plen_q <= plen_d;  dh_q <= dh_d;
      have_q <= have_d;  done_q <= done_d;  ended_q <= ended_d;  pk_q <= pk_d;
      pkc_q <= pkc_d;  ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;  cnt_q <= cnt_d;  disp_q <= disp_d;
    ob_q <= ob_d;  oc_q <= oc_d;  ol_q <= ol_d;  oe_q <= oe_d;
  end

endmodule

@@ rtl/core/mldp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mldp_checker
// Port-level checks on the depacker result channel.
// ----------------------------------------------------------------------------
module mldp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_bytes_i,
  input logic [3:0]  byte_count_i,
  input logic        run_last_i,
  input logic        end_of_stream_i
);
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("valid dropped");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_bytes_i) && $stable(byte_count_i))
    else $error("payload changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> byte_count_i <= 4'd8) else $error("byte count too large");

  a_eos_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && end_of_stream_i |-> run_last_i) else $error("end not on last");

  a_empty_eos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && byte_count_i == 4'd0 |-> end_of_stream_i && run_last_i)
    else $error("empty result without end code");
endmodule

bind megalz_depacker mldp_checker u_mldp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_bytes_i    (out_o.out_bytes),
  .byte_count_i   (out_o.byte_count),
  .run_last_i     (out_o.run_last),
  .end_of_stream_i(out_o.end_of_stream)
);
